/* src/flag_escape_frame_receiver_unit_defines.svh */
// ----------------------------------------------------------------------------
// Flag/escape frame receiver: assertion macros
// Shared property templates for the checker of the frame receiver.
// ----------------------------------------------------------------------------
`ifndef FLAG_ESCAPE_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define FLAG_ESCAPE_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FEFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define FEFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed (next cycle)");

`endif

/* src/fefr_pkg.sv */
// ----------------------------------------------------------------------------
// Flag/escape frame receiver package
// Shared types and constants of the frame receiver.
// ----------------------------------------------------------------------------
package fefr_pkg;

    // Default receive buffer size in bytes.
    localparam int BUFFER_BYTES_DEF = 64;

    // Frame layout: two control bytes and one code byte precede the data.
    localparam int HEADER_BYTES = 3;
    localparam int CODE_POS     = 2;
    localparam int CTRL_HI_POS  = 1;

    // Reset values of the configuration registers.
    localparam logic [7:0] FLAG_RESET   = 8'd126;
    localparam logic [7:0] ESCAPE_RESET = 8'd125;

    // Register index on the configuration port.
    typedef enum logic {
        REG_FLAG   = 1'b0,
        REG_ESCAPE = 1'b1
    } fefr_reg_t;

    // Event reported with every line byte.
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_OPEN    = 3'd1,
        EV_CTRL_LO = 3'd2,
        EV_CTRL_HI = 3'd3,
        EV_CODE    = 3'd4,
        EV_DATA    = 3'd5,
        EV_DONE    = 3'd6,
        EV_DROP    = 3'd7
    } fefr_event_t;

    // Receiver mode flags.
    typedef struct packed {
        logic in_frame;
        logic frame_valid;
        logic escape_pending;
    } fefr_status_t;

endpackage

/* src/fefr_step.sv */
// ----------------------------------------------------------------------------
// Flag/escape frame receiver: byte step
// Combinational deframing of one line byte: next state and reported event.
// ----------------------------------------------------------------------------
module fefr_step
    import fefr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int CW           = $clog2(BUFFER_BYTES + 3),
    parameter int DW           = $clog2(BUFFER_BYTES - 2)
)
(
    input  logic [7:0]    line_byte,
    input  logic [7:0]    flag_byte,
    input  logic [7:0]    escape_byte,
    input  fefr_status_t  status,
    input  logic [CW-1:0] byte_count,
    input  logic [15:0]   ctrl_word,
    input  logic [7:0]    code_byte,
    output fefr_status_t  status_next,
    output logic [CW-1:0] byte_count_next,
    output logic [15:0]   ctrl_word_next,
    output logic [7:0]    code_byte_next,
    output fefr_event_t   event_res,
    output logic [DW-1:0] data_index,
    output logic [DW-1:0] payload_length
);

    logic          take;
    logic [CW-1:0] idx_full;
    logic [CW-1:0] len_full;

    // Position of a data byte and payload length without header and checksum.
    assign idx_full = byte_count - CW'(HEADER_BYTES);
    assign len_full = byte_count - CW'(HEADER_BYTES + 1);

    // Flag and escape handling, then placement of a literal byte in the frame.
    always_comb
    begin
        status_next     = status;
        byte_count_next = byte_count;
        ctrl_word_next  = ctrl_word;
        code_byte_next  = code_byte;
        event_res       = EV_NONE;
        data_index      = '0;
        payload_length  = '0;
        take            = 1'b1;

        if (line_byte == flag_byte && !status.escape_pending)
        begin
            take = 1'b0;
            if (!status.in_frame)
            begin
                byte_count_next         = '0;
                ctrl_word_next          = '0;
                code_byte_next          = '0;
                status_next.in_frame    = 1'b1;
                status_next.frame_valid = 1'b1;
                event_res               = EV_OPEN;
            end
            else if (!status.frame_valid)
            begin
                status_next.in_frame = 1'b0;
                event_res            = EV_DROP;
            end
            else if (byte_count != '0)
            begin
                if (byte_count >= CW'(HEADER_BYTES + 1))
                begin
                    payload_length = len_full[DW-1:0];
                end
                status_next.in_frame    = 1'b0;
                status_next.frame_valid = 1'b0;
                event_res               = EV_DONE;
            end
        end
        else if (line_byte == escape_byte && status.frame_valid && !status.escape_pending)
        begin
            status_next.escape_pending = 1'b1;
            take                       = 1'b0;
        end

        if (take)
        begin
            if (status.frame_valid)
            begin
                if (byte_count == '0)
                begin
                    ctrl_word_next = {8'h00, line_byte};
                    event_res      = EV_CTRL_LO;
                end
                else if (byte_count == CW'(CTRL_HI_POS))
                begin
                    ctrl_word_next = {line_byte, ctrl_word[7:0]};
                    event_res      = EV_CTRL_HI;
                end
                else if (byte_count == CW'(CODE_POS))
                begin
                    code_byte_next = line_byte;
                    event_res      = EV_CODE;
                end
                else if (byte_count <= CW'(BUFFER_BYTES))
                begin
                    data_index = idx_full[DW-1:0];
                    event_res  = EV_DATA;
                end
                else
                begin
                    status_next.frame_valid = 1'b0;
                    event_res               = EV_DROP;
                end
                byte_count_next = byte_count + CW'(1);
            end
            status_next.escape_pending = 1'b0;
        end
    end

endmodule

/* src/flag_escape_frame_receiver_unit.sv */
// A result is registered: it appears in the output register in the cycle after its line byte is transferred.
// One line byte per cycle while the output register is not stalled; the per-byte step is one pass of shallow logic
// between the receiver state registers and the output register.
// The input stays ready while the output register is empty or being drained.
// Reset (rst_n low, asynchronous) closes any frame, clears the counters and the output valid,
// and returns flag and escape bytes to 126 and 125.
// ----------------------------------------------------------------------------
// Flag/escape frame receiver
// Deframes flag-delimited, escape-stuffed frames from a byte stream and
// reports one event per line byte.
// ----------------------------------------------------------------------------
module flag_escape_frame_receiver_unit
    import fefr_pkg::*;
#(
    parameter  int BUFFER_BYTES = BUFFER_BYTES_DEF,
    localparam int DW           = $clog2(BUFFER_BYTES - 2),
    localparam int OUT_W        = ((32 + 2 * DW + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    // Line byte stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] line_byte
    // Event stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // byte_value, data_index, control_word,
                                        // frame_code, payload_length, zero pad
    output logic [2:0]       m_tuser,   // [2:0] event_res
    // Configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW = $clog2(BUFFER_BYTES + 3);

    logic [7:0]       flag_reg;
    logic [7:0]       escape_reg;
    fefr_status_t     status_reg;
    fefr_status_t     status_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [15:0]      ctrl_reg;
    logic [15:0]      ctrl_next;
    logic [7:0]       code_reg;
    logic [7:0]       code_next;
    fefr_event_t      event_next;
    logic [DW-1:0]    index_next;
    logic [DW-1:0]    length_next;
    logic             valid_reg;
    logic [OUT_W-1:0] tdata_reg;
    logic [2:0]       tuser_reg;
    logic             in_xfer;
    logic             cfg_write;
    fefr_reg_t        reg_sel;

    // Configuration port: writes complete in the access cycle.
    assign pready    = 1'b1;
    assign reg_sel   = fefr_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_sel)
            REG_FLAG:   prdata = {24'h000000, flag_reg};
            REG_ESCAPE: prdata = {24'h000000, escape_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg   <= FLAG_RESET;
            escape_reg <= ESCAPE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_FLAG:   flag_reg   <= pwdata[7:0];
                REG_ESCAPE: escape_reg <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    // Input is taken whenever the output register is free or being drained.
    assign s_tready = !valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    fefr_step #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .CW           (CW),
        .DW           (DW)
    ) u_step (
        .line_byte       (s_tdata),
        .flag_byte       (flag_reg),
        .escape_byte     (escape_reg),
        .status          (status_reg),
        .byte_count      (count_reg),
        .ctrl_word       (ctrl_reg),
        .code_byte       (code_reg),
        .status_next     (status_next),
        .byte_count_next (count_next),
        .ctrl_word_next  (ctrl_next),
        .code_byte_next  (code_next),
        .event_res       (event_next),
        .data_index      (index_next),
        .payload_length  (length_next)
    );

    // Receiver state advances on every transferred byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= '0;
            count_reg  <= '0;
            ctrl_reg   <= '0;
            code_reg   <= '0;
        end
        else if (in_xfer)
        begin
            status_reg <= status_next;
            count_reg  <= count_next;
            ctrl_reg   <= ctrl_next;
            code_reg   <= code_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            tdata_reg <= OUT_W'({length_next, code_next, ctrl_next, index_next, s_tdata});
            tuser_reg <= event_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

/* src/fefr_checker.sv */
// ----------------------------------------------------------------------------
// Flag/escape frame receiver checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "flag_escape_frame_receiver_unit_defines.svh"

module fefr_checker
    import fefr_pkg::*;
#(
    parameter  int BUFFER_BYTES = BUFFER_BYTES_DEF,
    localparam int DW           = $clog2(BUFFER_BYTES - 2),
    localparam int OUT_W        = ((32 + 2 * DW + 7) / 8) * 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [2:0]       m_tuser
);

    logic [DW-1:0] data_index;
    logic [DW-1:0] payload_length;

    assign data_index     = m_tdata[8 +: DW];
    assign payload_length = m_tdata[32 + DW +: DW];

    // A stalled result holds its content.
    `FEFR_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // An empty output register never blocks the input.
    `FEFR_ASSERT_NOW(a_ready, clk, rst_n, !m_tvalid, s_tready)

    // Every transferred byte shows up as a result in the next cycle.
    `FEFR_ASSERT_NEXT(a_result, clk, rst_n, s_tvalid && s_tready, m_tvalid)

    // Index and length are zero outside data and frame-done events.
    `FEFR_ASSERT_NOW(a_index, clk, rst_n, m_tvalid && m_tuser != EV_DATA, data_index == '0)
    `FEFR_ASSERT_NOW(a_length, clk, rst_n, m_tvalid && m_tuser != EV_DONE,
        payload_length == '0)

endmodule

bind flag_escape_frame_receiver_unit fefr_checker #(
    .BUFFER_BYTES (BUFFER_BYTES)
) u_fefr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* verif/tb_flag_escape_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// Flag/escape frame receiver testbench
// Streams line bytes through the deframer under several flag and escape
// settings and random stalls on both streams. Every event transfer is checked
// against a local deframing predictor that tracks the frame state.
// ----------------------------------------------------------------------------
module tb_flag_escape_frame_receiver_unit
    import fefr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  BUF_BYTES   = BUFFER_BYTES_DEF;
    localparam int  DW          = $clog2(BUF_BYTES - 2);
    localparam int  OUT_W       = ((32 + 2 * DW + 7) / 8) * 8;
    localparam int  CYCLE_LIMIT = 400000;

    // One event as the block reports it.
    typedef struct packed {
        fefr_event_t     ev;
        logic [7:0]      byte_value;
        logic [DW-1:0]   data_index;
        logic [15:0]     control_word;
        logic [7:0]      frame_code;
        logic [DW-1:0]   payload_length;
    } rx_event_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;    // [7:0] line_byte
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;    // byte_value, data_index, control_word,
                                  // frame_code, payload_length, zero pad
    logic [2:0]       m_tuser;    // [2:0] event_res
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    // Deframer state and register copies used for prediction.
    logic             rx_in_frame;
    logic             rx_frame_valid;
    logic             rx_esc_pending;
    int               rx_count;
    logic [15:0]      rx_ctrl;
    logic [7:0]       rx_code;
    logic [7:0]       cfg_flag;
    logic [7:0]       cfg_escape;

    logic [7:0]       line_q[$];
    rx_event_t        event_q[$];
    int               items_pushed;
    int               items_taken;
    int               mismatches;
    int               cycle_count;
    int               send_idle_pct;
    int               recv_idle_pct;
    logic             line_taken;

    flag_escape_frame_receiver_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Run the deframer for one line byte and return the event it causes.
    function automatic rx_event_t deframe_byte(input logic [7:0] b);
        rx_event_t r;
        logic      take;
        take = 1'b1;
        r = '0;
        r.ev = EV_NONE;
        r.byte_value = b;
        if (b == cfg_flag && !rx_esc_pending)
        begin
            take = 1'b0;
            if (!rx_in_frame)
            begin
                rx_count = 0;
                rx_ctrl = '0;
                rx_code = '0;
                rx_in_frame = 1'b1;
                rx_frame_valid = 1'b1;
                r.ev = EV_OPEN;
            end
            else if (!rx_frame_valid)
            begin
                rx_in_frame = 1'b0;
                r.ev = EV_DROP;
            end
            else if (rx_count != 0)
            begin
                // The checksum byte and the header are not part of the payload.
                if (rx_count >= HEADER_BYTES + 1)
                    r.payload_length = DW'(rx_count - (HEADER_BYTES + 1));
                rx_in_frame = 1'b0;
                rx_frame_valid = 1'b0;
                r.ev = EV_DONE;
            end
        end
        else if (b == cfg_escape && rx_frame_valid && !rx_esc_pending)
        begin
            rx_esc_pending = 1'b1;
            take = 1'b0;
        end

        if (take)
        begin
            if (rx_frame_valid)
            begin
                if (rx_count == 0)
                begin
                    rx_ctrl = {8'd0, b};
                    r.ev = EV_CTRL_LO;
                end
                else if (rx_count == CTRL_HI_POS)
                begin
                    rx_ctrl = {b, rx_ctrl[7:0]};
                    r.ev = EV_CTRL_HI;
                end
                else if (rx_count == CODE_POS)
                begin
                    rx_code = b;
                    r.ev = EV_CODE;
                end
                else if (rx_count <= BUF_BYTES)
                begin
                    r.data_index = DW'(rx_count - HEADER_BYTES);
                    r.ev = EV_DATA;
                end
                else
                begin
                    rx_frame_valid = 1'b0;
                    r.ev = EV_DROP;
                end
                rx_count++;
            end
            rx_esc_pending = 1'b0;
        end
        r.control_word = rx_ctrl;
        r.frame_code = rx_code;
        return r;
    endfunction

    // Line byte driver: a new byte is presented once the previous one is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || line_taken)
        begin
            if (line_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= line_q.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predict on each line transfer, check each event transfer.
    always @(posedge clk)
    begin
        rx_event_t got;
        rx_event_t want;
        line_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            event_q.push_back(deframe_byte(s_tdata));
            items_taken++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ev             = fefr_event_t'(m_tuser);
            got.byte_value     = m_tdata[7:0];
            got.data_index     = m_tdata[8 +: DW];
            got.control_word   = m_tdata[8 + DW +: 16];
            got.frame_code     = m_tdata[24 + DW +: 8];
            got.payload_length = m_tdata[32 + DW +: DW];
            if (event_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: event transfer with none pending: ev=%0d byte=%02h",
                             $realtime, got.ev, got.byte_value);
            end
            else
            begin
                want = event_q.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: event mismatch", $realtime);
                        $display("  exp ev=%0d byte=%02h idx=%0d ctrl=%04h code=%02h len=%0d",
                                 want.ev, want.byte_value, want.data_index,
                                 want.control_word, want.frame_code, want.payload_length);
                        $display("  got ev=%0d byte=%02h idx=%0d ctrl=%04h code=%02h len=%0d",
                                 got.ev, got.byte_value, got.data_index,
                                 got.control_word, got.frame_code, got.payload_length);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_line(input logic [7:0] b);
        line_q.push_back(b);
        items_pushed++;
    endtask

    // Wait until every queued byte is taken and every event has been checked.
    task automatic wait_drained();
        while (items_taken != items_pushed || event_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input fefr_reg_t idx, input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FLAG)
            cfg_flag = value;
        else
            cfg_escape = value;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 36;
                recv_idle_pct = 72;
            end
            1:
            begin
                send_idle_pct = 72;
                recv_idle_pct = 36;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Byte content biased toward the flag, the escape and the extremes.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(15);
        case (r)
            0, 1: return cfg_flag;
            2, 3: return cfg_escape;
            4: return 8'h00;
            5: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Queue one frame with stuffed content; optionally leave it unclosed.
    task automatic queue_frame(input int n_body, input bit closed);
        logic [7:0] b;
        push_line(cfg_flag);
        for (int i = 0; i < n_body; i++)
        begin
            b = pick_byte();
            // With equal flag and escape, such a byte cannot be carried at all.
            if (cfg_flag == cfg_escape && b == cfg_flag)
                b = ~b;
            else if (b == cfg_flag || b == cfg_escape)
                push_line(cfg_escape);
            push_line(b);
        end
        if (closed)
            push_line(cfg_flag);
    endtask

    initial
    begin : stimulus
        logic [7:0] phase_flag[5];
        logic [7:0] phase_escape[5];
        int         target;
        int         sel;
        int         n;

        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        line_taken = 1'b0;
        items_pushed = 0;
        items_taken = 0;
        mismatches = 0;
        cycle_count = 0;
        rx_in_frame = 1'b0;
        rx_frame_valid = 1'b0;
        rx_esc_pending = 1'b0;
        rx_count = 0;
        rx_ctrl = '0;
        rx_code = '0;
        cfg_flag = FLAG_RESET;
        cfg_escape = ESCAPE_RESET;
        set_idling(0);

        phase_flag   = '{8'h00, 8'hFF, 8'h7E, 8'($urandom), FLAG_RESET};
        phase_escape = '{8'hFF, 8'h00, 8'h7E, 8'($urandom), ESCAPE_RESET};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset register values.
        push_line(ESCAPE_RESET);        // escape outside a frame is a plain byte
        push_line(FLAG_RESET);          // open
        push_line(FLAG_RESET);          // empty frame, stays open
        push_line(8'h00);
        push_line(8'hFF);
        push_line(ESCAPE_RESET);        // escaped flag as the code byte
        push_line(FLAG_RESET);
        push_line(ESCAPE_RESET);        // escaped escape as data
        push_line(ESCAPE_RESET);
        push_line(8'h80);
        push_line(8'h01);               // checksum
        push_line(FLAG_RESET);          // done
        push_line(FLAG_RESET);          // short frame with a single byte
        push_line(8'hAA);
        push_line(FLAG_RESET);

        // Random frames under each register setting.
        for (int p = 0; p < 5; p++)
        begin
            wait_drained();
            repeat (3) @(negedge clk);
            write_reg(REG_FLAG, phase_flag[p]);
            write_reg(REG_ESCAPE, phase_escape[p]);
            set_idling(p < 2 ? 0 : (p < 4 ? 1 : 2));
            target = items_pushed + 320;
            while (items_pushed < target)
            begin
                sel = $urandom_range(99);
                if (sel < 70)
                begin
                    n = $urandom_range(12);
                    queue_frame(n, 1'b1);
                end
                else if (sel < 76)
                begin
                    // Long frames; those with more than 65 body bytes run past the buffer.
                    n = $urandom_range(58, 70);
                    queue_frame(n, 1'b1);
                end
                else if (sel < 86)
                begin
                    n = $urandom_range(1, 8);
                    queue_frame(n, 1'b0);
                    if ($urandom_range(1))
                        push_line(cfg_flag);
                end
                else
                begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                        push_line(pick_byte());
                    if ($urandom_range(1))
                        push_line(cfg_flag);
                end
                // Now and then let the block run dry before feeding more.
                if ($urandom_range(39) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && event_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
